[rtl/core/ookpw_pkg.sv]
// ookpw_pkg: shared types and constants of the pulse-width ook symbol encoder
// used by ook_pulse_width_symbol_encoder; depends on nothing else

package ookpw_pkg;

    // widths of the item fields and registers
    localparam int TICKS_W = 15;
    localparam int BASE_W  = 12;
    localparam int FACT_W  = 6;
    localparam int DUR_W   = BASE_W + FACT_W;
    localparam int CFG_A_W = 3;

    // default split limit for long halves
    localparam int MAX_CHUNK_TICKS_DEF = 32767;

    // symbols delivered per item at most
    localparam int MAX_RES = 17;
    localparam int CNT_W   = 5;

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_BASE_UNIT = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_INVERT    = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_ONE_HI    = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_ONE_LO    = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_ZERO_HI   = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_ZERO_LO   = 3'd5;
    localparam logic [CFG_A_W-1:0] REG_SYNC_HI   = 3'd6;
    localparam logic [CFG_A_W-1:0] REG_SYNC_LO   = 3'd7;

    // register reset values
    localparam logic [BASE_W-1:0] RST_BASE_UNIT = 12'd350;
    localparam logic [FACT_W-1:0] RST_ONE_HI    = 6'd3;
    localparam logic [FACT_W-1:0] RST_ONE_LO    = 6'd1;
    localparam logic [FACT_W-1:0] RST_ZERO_HI   = 6'd1;
    localparam logic [FACT_W-1:0] RST_ZERO_LO   = 6'd3;
    localparam logic [FACT_W-1:0] RST_SYNC_HI   = 6'd1;
    localparam logic [FACT_W-1:0] RST_SYNC_LO   = 6'd31;

    // one symbol, first_level in the lowest bit
    typedef struct packed {
        logic [TICKS_W-1:0] second_ticks;
        logic               second_level;
        logic [TICKS_W-1:0] first_ticks;
        logic               first_level;
    } t_sym;

endpackage

[rtl/core/ook_pulse_width_symbol_encoder.sv]
// ook_pulse_width_symbol_encoder: turns data bits into paired pulse-width symbols
// one shared multiplier and one chunk subtractor under a small sequencer
// depends on ookpw_pkg
//
//  channel  | dir | payload
//  ---------+-----+-------------------------------------------------------------
//  s_axis   | in  | tdata[0] data_bit, tlast word_end, tuser stream_end
//  m_axis   | out | tdata first_level/first_ticks/second_level/second_ticks,
//           |     | tlast run_last, tuser stream_done
//  cfg      | in  | we, addr (register index), data (12 bit)
//
// each half of a pulse passes the shared multiplier (ST_MUL) and then the subtractor
// chunk by chunk (ST_CHUNK); a half of zero length passes it without a chunk
// the block is ready only between items; output stalls back up into the sequencer
// synchronous active-low reset clears control state and the configuration

module ook_pulse_width_symbol_encoder #(
    parameter int MAX_CHUNK_TICKS = ookpw_pkg::MAX_CHUNK_TICKS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input items
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,   // [0] data_bit, [7:1] zero
    input  logic                          i_s_tlast,   // word_end
    input  logic                          i_s_tuser,   // stream_end
    // result items
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [31:0]                   o_m_tdata,   // [0] first_level,
                                                       // [15:1] first_ticks,
                                                       // [16] second_level,
                                                       // [31:17] second_ticks
    output logic                          o_m_tlast,   // run_last
    output logic                          o_m_tuser,   // stream_done
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic [ookpw_pkg::CFG_A_W-1:0] i_cfg_addr,
    input  logic [ookpw_pkg::BASE_W-1:0]  i_cfg_data
);

    localparam int TW = ookpw_pkg::TICKS_W;
    localparam int DW = ookpw_pkg::DUR_W;
    localparam int FW = ookpw_pkg::FACT_W;
    localparam int CW = ookpw_pkg::CNT_W;
    localparam logic [DW-1:0] LIM = DW'(MAX_CHUNK_TICKS);
    localparam logic [CW-1:0] CNT_MAX = CW'(ookpw_pkg::MAX_RES);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_CHUNK = 3'd2;
    localparam logic [2:0] ST_FLUSH = 3'd3;
    localparam logic [2:0] ST_FINAL = 3'd4;

    // configuration registers
    logic [ookpw_pkg::BASE_W-1:0] r_base;
    logic                         r_inv;
    logic [FW-1:0]                r_one_hi, r_one_lo, r_zero_hi, r_zero_lo;
    logic [FW-1:0]                r_sync_hi, r_sync_lo;

    // control state
    logic [2:0]    r_state, n_state;
    logic          r_pend, n_pend;
    logic          r_held_l, n_held_l;
    logic [TW-1:0] r_held_t, n_held_t;
    logic          r_stg_valid, n_stg_valid;
    logic          r_out_valid, n_out_valid;
    logic [CW-1:0] r_cnt, n_cnt;

    // item and payload registers
    logic             r_bit, n_bit, r_wend, n_wend, r_send, n_send;
    logic [1:0]       r_h, n_h;
    logic [DW-1:0]    r_dur, n_dur;
    ookpw_pkg::t_sym  r_stg, n_stg, r_out, n_out;
    logic             r_out_last, n_out_last, r_out_done, n_out_done;

    // datapath
    logic [FW-1:0]   fac;
    logic [DW-1:0]   prod;
    logic [TW-1:0]   chunk;
    logic [DW-1:0]   rem;
    logic            lvl;
    logic            out_free;
    logic            emit;
    logic            stall;
    logic            adv;
    ookpw_pkg::t_sym e_sym;

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= ookpw_pkg::RST_BASE_UNIT;
            r_inv     <= 1'b0;
            r_one_hi  <= ookpw_pkg::RST_ONE_HI;
            r_one_lo  <= ookpw_pkg::RST_ONE_LO;
            r_zero_hi <= ookpw_pkg::RST_ZERO_HI;
            r_zero_lo <= ookpw_pkg::RST_ZERO_LO;
            r_sync_hi <= ookpw_pkg::RST_SYNC_HI;
            r_sync_lo <= ookpw_pkg::RST_SYNC_LO;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                ookpw_pkg::REG_BASE_UNIT: r_base    <= i_cfg_data;
                ookpw_pkg::REG_INVERT:    r_inv     <= i_cfg_data[0];
                ookpw_pkg::REG_ONE_HI:    r_one_hi  <= i_cfg_data[FW-1:0];
                ookpw_pkg::REG_ONE_LO:    r_one_lo  <= i_cfg_data[FW-1:0];
                ookpw_pkg::REG_ZERO_HI:   r_zero_hi <= i_cfg_data[FW-1:0];
                ookpw_pkg::REG_ZERO_LO:   r_zero_lo <= i_cfg_data[FW-1:0];
                ookpw_pkg::REG_SYNC_HI:   r_sync_hi <= i_cfg_data[FW-1:0];
                ookpw_pkg::REG_SYNC_LO:   r_sync_lo <= i_cfg_data[FW-1:0];
                default: ;
            endcase
        end
    end

    // factor of the current half: data high, data low, sync high, sync low
    always_comb begin
        case (r_h)
            2'd0:    fac = r_bit ? r_one_hi : r_zero_hi;
            2'd1:    fac = r_bit ? r_one_lo : r_zero_lo;
            2'd2:    fac = r_sync_hi;
            2'd3:    fac = r_sync_lo;
            default: fac = r_sync_lo;
        endcase
    end

    // shared multiplier and chunk subtractor
    assign prod  = DW'(fac) * DW'(r_base);
    assign chunk = (r_dur > LIM) ? TW'(LIM) : r_dur[TW-1:0];
    assign rem   = r_dur - DW'(chunk);
    assign lvl   = r_h[0] ? r_inv : ~r_inv;

    assign out_free = !r_out_valid || i_m_tready;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_pend      = r_pend;
        n_held_l    = r_held_l;
        n_held_t    = r_held_t;
        n_stg_valid = r_stg_valid;
        n_out_valid = r_out_valid;
        n_cnt       = r_cnt;
        n_bit       = r_bit;
        n_wend      = r_wend;
        n_send      = r_send;
        n_h         = r_h;
        n_dur       = r_dur;
        n_stg       = r_stg;
        n_out       = r_out;
        n_out_last  = r_out_last;
        n_out_done  = r_out_done;
        emit        = 1'b0;
        adv         = 1'b0;
        e_sym       = '{second_ticks: chunk, second_level: lvl,
                        first_ticks: r_held_t, first_level: r_held_l};

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        // a staged symbol must move out before a new one takes its place
        stall = (r_cnt < CNT_MAX) && r_stg_valid && !out_free;

        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_bit   = i_s_tdata[0];
                    n_wend  = i_s_tlast;
                    n_send  = i_s_tuser;
                    n_h     = 2'd0;
                    n_cnt   = '0;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_dur   = prod;
                n_state = ST_CHUNK;
            end
            ST_CHUNK: begin
                if (r_dur == '0) begin
                    adv = 1'b1;
                end else if (!r_pend) begin
                    n_held_l = lvl;
                    n_held_t = chunk;
                    n_pend   = 1'b1;
                    n_dur    = rem;
                    adv      = (rem == '0);
                end else begin
                    emit = 1'b1;
                    if (!stall) begin
                        n_pend = 1'b0;
                        n_dur  = rem;
                        adv    = (rem == '0);
                    end
                end
            end
            ST_FLUSH: begin
                if (r_send && r_pend) begin
                    emit  = 1'b1;
                    e_sym = '{second_ticks: '0, second_level: 1'b0,
                              first_ticks: r_held_t, first_level: r_held_l};
                    if (!stall) begin
                        n_pend   = 1'b0;
                        n_held_l = 1'b0;
                        n_held_t = '0;
                        n_state  = ST_FINAL;
                    end
                end else begin
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: begin
                // last staged symbol carries the end marks
                if (!r_stg_valid) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out       = r_stg;
                    n_out_last  = 1'b1;
                    n_out_done  = r_send;
                    n_out_valid = 1'b1;
                    n_stg_valid = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // next half, or flush once the last half is done
        if (adv) begin
            if ((r_h == 2'd1 && !r_wend) || r_h == 2'd3) begin
                n_state = ST_FLUSH;
            end else begin
                n_h     = r_h + 2'd1;
                n_state = ST_MUL;
            end
        end

        // stage a new symbol, pushing the previous one out; beyond the cap it is dropped
        if (emit && !stall && r_cnt < CNT_MAX) begin
            if (r_stg_valid) begin
                n_out       = r_stg;
                n_out_last  = 1'b0;
                n_out_done  = 1'b0;
                n_out_valid = 1'b1;
            end
            n_stg       = e_sym;
            n_stg_valid = 1'b1;
            n_cnt       = r_cnt + CW'(1);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pend      <= 1'b0;
            r_held_l    <= 1'b0;
            r_held_t    <= '0;
            r_stg_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_held_l    <= n_held_l;
            r_held_t    <= n_held_t;
            r_stg_valid <= n_stg_valid;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_bit      <= n_bit;
        r_wend     <= n_wend;
        r_send     <= n_send;
        r_h        <= n_h;
        r_dur      <= n_dur;
        r_stg      <= n_stg;
        r_out      <= n_out;
        r_out_last <= n_out_last;
        r_out_done <= n_out_done;
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_done;

    // nothing stays staged between items
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_stg_valid)
        else $error("staged symbol left over between items");

    // symbol count never passes the cap
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_MAX)
        else $error("symbol count beyond cap");

    // stream end mark only on the closing symbol of an item
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> o_m_tlast)
        else $error("stream_done without run_last");

    // an accepted item starts in the multiplier
    a_accept_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == ST_MUL && r_h == 2'd0))
        else $error("accepted item did not start a pulse");

    // a flush at stream end leaves no half pending
    a_flush_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINAL && r_send) |-> !r_pend)
        else $error("pending half survived stream end");

endmodule
